[rtl/sdr_pkg.sv]
// Shared definitions for the SD card SPI-mode responder: command codes,
// reply bytes, sizes and the decoded-command record. No dependencies.
`timescale 1ns / 1ps

package sdr_pkg;

  // Sizes
  localparam int SECTOR_BYTES = 512;
  localparam int WIN_DEPTH    = 6;
  localparam int RSP_DEPTH    = 5;
  localparam int RSP_CNT_W    = 3;
  localparam int SECTOR_W     = 32;
  localparam int MEM_OFFSET_W = 9;

  // Command bytes as seen in the second-oldest window slot
  localparam logic [7:0] OP_GO_IDLE   = 8'h40;
  localparam logic [7:0] OP_IF_COND   = 8'h48;
  localparam logic [7:0] OP_STOP      = 8'h4c;
  localparam logic [7:0] OP_READ_ONE  = 8'h51;
  localparam logic [7:0] OP_READ_MANY = 8'h52;
  localparam logic [7:0] OP_APP_INIT  = 8'h69;
  localparam logic [7:0] OP_APP_CMD   = 8'h77;
  localparam logic [7:0] OP_READ_OCR  = 8'h7a;

  // Line fill values and reply bytes
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_IDLE   = 8'hff;
  localparam logic [7:0] TOKEN_START = 8'hfe;
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_PARAM    = 8'h40;
  localparam logic [7:0] R7_CHECK    = 8'haa;
  localparam logic [7:0] OCR_TOP     = 8'h40;

  // Decoded command: reply bytes in stored order, sent from the top down
  typedef struct packed {
    logic [RSP_DEPTH-1:0][7:0] bytes;
    logic [RSP_CNT_W-1:0]      count;
    logic                      is_read;
    logic                      multi;
  } sdr_rsp_t;

endpackage

[rtl/sdr_cmd_decode.sv]
// Command decoder: maps a command byte to its queued reply and read flags.
// Depends on sdr_pkg.
`timescale 1ns / 1ps

module sdr_cmd_decode (
  input  logic [7:0]        op_i,
  output sdr_pkg::sdr_rsp_t rsp_o
);
  import sdr_pkg::*;

  // Pick the reply for the command byte
  always_comb begin
    rsp_o         = '0;
    rsp_o.count   = RSP_CNT_W'(1);
    rsp_o.multi   = (op_i == OP_READ_MANY);
    rsp_o.is_read = 1'b0;
    case (op_i)
      OP_GO_IDLE, OP_APP_CMD: begin
        rsp_o.bytes[0] = R1_IDLE;
      end
      OP_STOP, OP_APP_INIT: begin
        rsp_o.bytes[0] = R1_READY;
      end
      OP_IF_COND: begin
        rsp_o.bytes = {R1_IDLE, BYTE_ZERO, BYTE_ZERO, R1_IDLE, R7_CHECK};
        rsp_o.count = RSP_CNT_W'(RSP_DEPTH);
      end
      OP_READ_OCR: begin
        rsp_o.bytes = {R1_READY, OCR_TOP, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO};
        rsp_o.count = RSP_CNT_W'(RSP_DEPTH);
      end
      OP_READ_ONE, OP_READ_MANY: begin
        rsp_o.bytes[0] = R1_READY;
        rsp_o.is_read  = 1'b1;
      end
      default: begin
        rsp_o.bytes[0] = R1_PARAM;
      end
    endcase
  end

endmodule

[rtl/sd_card_spi_mode_responder.sv]
// SD card SPI-mode responder, card side, one exchanged byte per transaction.
// All work is one pass from state to result, registered in the output register.
// Throughput: one transaction per cycle while the input is not stalled.
// The output register stalls the input only while it is full and held.
// Reset (asynchronous, active low) clears the window, reply queue and block state.
`timescale 1ns / 1ps

module sd_card_spi_mode_responder #(
  parameter int SectorBytes = sdr_pkg::SECTOR_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    mosi_byte_i,
  input  logic                          card_selected_i,
  input  logic [7:0]                    mem_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    miso_byte_o,
  output logic [sdr_pkg::SECTOR_W-1:0]  mem_sector_o,
  output logic [sdr_pkg::MEM_OFFSET_W-1:0] mem_offset_o,
  output logic                          mem_read_o
);
  import sdr_pkg::*;

  localparam int BlockTotal = SectorBytes + 1 + 2;
  localparam int RemW       = $clog2(BlockTotal + 1);
  localparam logic [RemW-1:0] BlockTotalW = RemW'(BlockTotal);
  localparam logic [RemW-1:0] SectorW     = RemW'(SectorBytes);
  localparam logic [RemW-1:0] OneW        = RemW'(1);

  logic [WIN_DEPTH-1:0][7:0] win_q, win_d;
  logic [RSP_DEPTH-1:0][7:0] rsp_q, rsp_d;
  logic [RSP_CNT_W-1:0]      cnt_q, cnt_d;
  logic [RemW-1:0]           rem_q, rem_d;
  logic [SECTOR_W-1:0]       sector_q, sector_d;
  logic                      multi_q, multi_d;

  logic                      out_valid_q;
  logic [7:0]                miso_q, miso_d;
  logic [SECTOR_W-1:0]       req_sector_q, req_sector_d;
  logic [MEM_OFFSET_W-1:0]   req_offset_q, req_offset_d;
  logic                      req_read_q, req_read_d;

  logic [7:0]      op;
  logic [RemW-1:0] idx_cur;
  logic [RemW-1:0] idx_next;
  logic [RemW-1:0] off_full;
  logic            in_accept;
  sdr_rsp_t        dec;

  // Hold input while a result waits and is not taken
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;

  assign op = win_q[1];

  sdr_cmd_decode u_cmd_decode (
    .op_i  (op),
    .rsp_o (dec)
  );

  // Advance the window, reply queue and block counter for one transaction
  always_comb begin
    win_d    = win_q;
    rsp_d    = rsp_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    sector_d = sector_q;
    multi_d  = multi_q;
    miso_d   = BYTE_ZERO;
    idx_cur  = BlockTotalW - rem_q;
    if (!card_selected_i) begin
      miso_d = (mosi_byte_i == BYTE_IDLE) ? BYTE_IDLE : BYTE_ZERO;
    end else begin
      win_d = {mosi_byte_i, win_q[WIN_DEPTH-1:1]};
      if (!(op inside {BYTE_ZERO, BYTE_IDLE})) begin
        // Decode the full window, then clear it
        win_d   = '0;
        miso_d  = BYTE_ZERO;
        cnt_d   = dec.count;
        multi_d = dec.multi;
        if (dec.count == RSP_CNT_W'(RSP_DEPTH)) begin
          rsp_d = dec.bytes;
        end else begin
          rsp_d[0] = dec.bytes[0];
        end
        if (dec.is_read) begin
          sector_d = {win_q[2], win_q[3], win_q[4], win_q[5]};
          rem_d    = BlockTotalW;
        end
      end else if (rem_q != '0 && cnt_q == '0) begin
        // Send the next block byte: token, sector data, then CRC
        if (idx_cur == '0) begin
          miso_d = TOKEN_START;
        end else if (idx_cur <= SectorW) begin
          miso_d = mem_byte_i;
        end else begin
          miso_d = BYTE_ZERO;
        end
        rem_d = rem_q - OneW;
        if (rem_d == '0 && multi_q) begin
          sector_d = sector_q + SECTOR_W'(1);
          rem_d    = BlockTotalW;
        end
      end else if (cnt_q != '0) begin
        cnt_d  = cnt_q - RSP_CNT_W'(1);
        miso_d = rsp_q[cnt_d];
      end else begin
        miso_d = BYTE_IDLE;
      end
    end
  end

  // Request the sector byte that the next transaction will send
  always_comb begin
    idx_next     = BlockTotalW - rem_d;
    off_full     = idx_next - OneW;
    req_read_d   = (rem_d != '0) && (idx_next inside {[OneW:SectorW]});
    req_sector_d = req_read_d ? sector_d : '0;
    req_offset_d = req_read_d ? MEM_OFFSET_W'(off_full) : '0;
  end

  // Hold card state; update on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      rsp_q    <= '0;
      cnt_q    <= '0;
      rem_q    <= '0;
      sector_q <= '0;
      multi_q  <= 1'b0;
    end else if (in_accept) begin
      win_q    <= win_d;
      rsp_q    <= rsp_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      sector_q <= sector_d;
      multi_q  <= multi_d;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      miso_q       <= miso_d;
      req_sector_q <= req_sector_d;
      req_offset_q <= req_offset_d;
      req_read_q   <= req_read_d;
    end
  end

  assign miso_byte_o  = miso_q;
  assign mem_sector_o = req_sector_q;
  assign mem_offset_o = req_offset_q;
  assign mem_read_o   = req_read_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RSP_CNT_W'(RSP_DEPTH))
    else $error("reply count beyond queue depth");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= BlockTotalW)
    else $error("block counter beyond block length");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_req_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mem_read_o) |-> (mem_sector_o == '0 && mem_offset_o == '0))
    else $error("memory request fields set without a read");

endmodule

[sim/sd_card_spi_mode_responder_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for sd_card_spi_mode_responder: drives host bytes, predicts each
// card reply and memory request, and compares them field by field. Needs sdr_pkg and the RTL.

module sd_card_spi_mode_responder_test;
  import sdr_pkg::*;

  // Block is token, sector bytes and two CRC bytes
  localparam int          BlockTotal = SECTOR_BYTES + 1 + 2;
  localparam logic [7:0]  OP_UNKNOWN = 8'h41;
  localparam logic [7:0]  R7_VOLTAGE = 8'h01;
  localparam logic [7:0]  CRC_GO_IDLE = 8'h95;
  localparam logic [7:0]  CRC_IF_COND = 8'h87;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 64;

  typedef struct packed {
    logic [7:0]              miso;
    logic [SECTOR_W-1:0]     sector;
    logic [MEM_OFFSET_W-1:0] offset;
    logic                    fetch;
  } card_reply_t;

  // Card behaviour: tracks the window, the reply queue and the block read
  class card_reply_predictor;
    logic [7:0]          window [WIN_DEPTH];
    logic [7:0]          rsp [RSP_DEPTH];
    int unsigned         rsp_count;
    int unsigned         block_left;
    logic [SECTOR_W-1:0] sector;
    bit                  multi;
    card_reply_t         replies_due [$];
    int unsigned         mismatches;

    function new();
      foreach (window[i]) window[i] = BYTE_ZERO;
      foreach (rsp[i]) rsp[i] = BYTE_ZERO;
      rsp_count  = 0;
      block_left = 0;
      sector     = '0;
      multi      = 1'b0;
      mismatches = 0;
    endfunction

    // Store reply bytes in stored order; they leave from the last stored back
    function void queue_rsp(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
                            logic [7:0] e, int unsigned count);
      rsp[0]    = a;
      rsp[1]    = b;
      rsp[2]    = c;
      rsp[3]    = d;
      rsp[4]    = e;
      rsp_count = count;
    endfunction

    // Advance the card by one accepted transaction and hold its expected reply
    function void note_exchange(logic [7:0] mosi, logic sel, logic [7:0] mem);
      card_reply_t r;
      logic [7:0]  op;
      int unsigned idx;
      r = '0;
      if (!sel) begin
        r.miso = (mosi == BYTE_IDLE) ? BYTE_IDLE : BYTE_ZERO;
      end else begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) window[i] = window[i + 1];
        window[WIN_DEPTH - 1] = mosi;
        op = window[0];
        if (op != BYTE_ZERO && op != BYTE_IDLE) begin
          // decode the window, then clear it
          multi = (op == OP_READ_MANY);
          case (op)
            OP_GO_IDLE, OP_APP_CMD: begin
              queue_rsp(R1_IDLE, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, 1);
            end
            OP_STOP, OP_APP_INIT: begin
              queue_rsp(R1_READY, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, 1);
            end
            OP_IF_COND: begin
              queue_rsp(R7_CHECK, R7_VOLTAGE, BYTE_ZERO, BYTE_ZERO, R1_IDLE, RSP_DEPTH);
            end
            OP_READ_OCR: begin
              queue_rsp(BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, OCR_TOP, R1_READY, RSP_DEPTH);
            end
            OP_READ_ONE, OP_READ_MANY: begin
              sector = {window[1], window[2], window[3], window[4]};
              queue_rsp(R1_READY, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, 1);
              block_left = BlockTotal;
            end
            default: begin
              queue_rsp(R1_PARAM, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, 1);
            end
          endcase
          foreach (window[i]) window[i] = BYTE_ZERO;
          r.miso = BYTE_ZERO;
        end else if (block_left != 0 && rsp_count == 0) begin
          // data block: token, sector bytes, zero CRC
          idx = BlockTotal - block_left;
          if (idx == 0) r.miso = TOKEN_START;
          else if (idx <= SECTOR_BYTES) r.miso = mem;
          else r.miso = BYTE_ZERO;
          block_left--;
          if (block_left == 0 && multi) begin
            sector     = sector + SECTOR_W'(1);
            block_left = BlockTotal;
          end
        end else if (rsp_count != 0) begin
          rsp_count--;
          r.miso = rsp[rsp_count];
        end else begin
          r.miso = BYTE_IDLE;
        end
      end
      // request fields describe the next byte to send
      if (block_left != 0) begin
        idx = BlockTotal - block_left;
        if (idx >= 1 && idx <= SECTOR_BYTES) begin
          r.fetch  = 1'b1;
          r.sector = sector;
          r.offset = MEM_OFFSET_W'(idx - 1);
        end
      end
      replies_due.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one result transaction with the oldest expected reply
    task check_reply(card_reply_t got);
      card_reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply %h with no transaction outstanding", got.miso));
        return;
      end
      want = replies_due.pop_front();
      if (got.miso !== want.miso)
        report($sformatf("miso_byte got %h expected %h", got.miso, want.miso));
      if (got.sector !== want.sector)
        report($sformatf("mem_sector got %h expected %h", got.sector, want.sector));
      if (got.offset !== want.offset)
        report($sformatf("mem_offset got %h expected %h", got.offset, want.offset));
      if (got.fetch !== want.fetch)
        report($sformatf("mem_read got %b expected %b", got.fetch, want.fetch));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              mosi_byte;
  logic                    card_selected;
  logic [7:0]              mem_byte;
  logic                    out_valid;
  logic                    out_stall;
  logic [7:0]              miso_byte;
  logic [SECTOR_W-1:0]     mem_sector;
  logic [MEM_OFFSET_W-1:0] mem_offset;
  logic                    mem_read;

  int                  phase = 0;
  int unsigned         cycles = 0;
  card_reply_predictor predictor;

  sd_card_spi_mode_responder #(
    .SectorBytes(SECTOR_BYTES)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mosi_byte_i    (mosi_byte),
    .card_selected_i(card_selected),
    .mem_byte_i     (mem_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .miso_byte_o    (miso_byte),
    .mem_sector_o   (mem_sector),
    .mem_offset_o   (mem_offset),
    .mem_read_o     (mem_read)
  );

  always #2 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Idle rate per phase: sender light then heavy, receiver the other way round
  function automatic int unsigned idle_pct(input bit sender);
    case (phase)
      0: return sender ? 22 : 58;
      1: return sender ? 58 : 22;
      default: return 0;
    endcase
  endfunction

  // Offer one host byte and wait until the transaction is taken
  task automatic send_byte(input logic [7:0] mosi, input logic sel);
    logic [7:0] mem;
    mem = 8'($urandom);
    while ($urandom_range(99, 0) < idle_pct(1'b1)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    mosi_byte     <= mosi;
    card_selected <= sel;
    mem_byte      <= mem;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predictor.note_exchange(mosi, sel, mem);
  endtask

  task automatic send_frame(input logic [7:0] op, input logic [31:0] arg,
                            input logic [7:0] crc);
    send_byte(op, 1'b1);
    send_byte(arg[31:24], 1'b1);
    send_byte(arg[23:16], 1'b1);
    send_byte(arg[15:8], 1'b1);
    send_byte(arg[7:0], 1'b1);
    send_byte(crc, 1'b1);
  endtask

  // Clock out reply bytes with fill bytes, now and then zero fill
  task automatic read_bytes(input int unsigned n);
    repeat (n) send_byte(($urandom_range(9, 0) == 0) ? BYTE_ZERO : BYTE_IDLE, 1'b1);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(8, 0))
      0: return OP_GO_IDLE;
      1: return OP_IF_COND;
      2: return OP_STOP;
      3: return OP_READ_ONE;
      4: return OP_READ_MANY;
      5: return OP_APP_INIT;
      6: return OP_APP_CMD;
      7: return OP_READ_OCR;
      default: return 8'($urandom_range(254, 1));
    endcase
  endfunction

  // Mostly whole commands with replies read back, the rest noise and cut frames
  task automatic random_units(input int unsigned n);
    int unsigned kind;
    for (int unsigned u = 0; u < n; u++) begin
      kind = $urandom_range(99, 0);
      if (kind < 8) begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom), 1'b1);
      end else if (kind < 16) begin
        repeat ($urandom_range(4, 1))
          send_byte(($urandom_range(2, 0) == 0) ? BYTE_IDLE : 8'($urandom), 1'b0);
      end else if (kind < 22) begin
        // cut frame: the following transactions finish the window
        send_byte(pick_op(), 1'b1);
        repeat ($urandom_range(4, 0)) send_byte(8'($urandom), 1'b1);
      end else begin
        send_frame(pick_op(), $urandom, 8'($urandom));
        read_bytes($urandom_range(12, 0));
      end
    end
  endtask

  // Receiver: take results, stall at random, and once hold off for a long stretch
  initial begin : drain_replies
    card_reply_t got;
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.miso   = miso_byte;
        got.sector = mem_sector;
        got.offset = mem_offset;
        got.fetch  = mem_read;
        predictor.check_reply(got);
      end
      if (phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < idle_pct(1'b0));
      end
    end
  end

  initial begin : host_stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    mosi_byte     = BYTE_IDLE;
    card_selected = 1'b0;
    mem_byte      = BYTE_ZERO;
    predictor     = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: deselected card, R7 and OCR replies, unknown command, stop
    send_byte(BYTE_IDLE, 1'b0);
    send_byte(BYTE_ZERO, 1'b0);
    send_frame(OP_IF_COND, 32'h0000_01aa, CRC_IF_COND);
    send_frame(OP_READ_OCR, 32'h0000_0000, BYTE_IDLE);
    send_frame(OP_UNKNOWN, 32'hffff_ffff, CRC_GO_IDLE);
    send_frame(OP_STOP, 32'h0000_0000, BYTE_ZERO);
    read_bytes(2);

    // Start of a single block from sector zero; later traffic cuts into the rest
    send_frame(OP_READ_ONE, 32'h0000_0000, BYTE_ZERO);
    read_bytes(24);
    random_units(10);

    // Multi-block read across the sector wrap, then stop it
    phase = 1;
    send_frame(OP_READ_MANY, 32'hffff_ffff, BYTE_ZERO);
    read_bytes(BlockTotal + 8);
    send_frame(OP_STOP, 32'h0000_0000, BYTE_ZERO);
    read_bytes(4);
    random_units(8);

    phase = 2;
    random_units(8);
    in_valid <= 1'b0;

    // Drain outstanding replies, then allow the output register to settle
    while (predictor.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (predictor.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sdr_pkg.sv
rtl/sdr_cmd_decode.sv
rtl/sd_card_spi_mode_responder.sv
sim/sd_card_spi_mode_responder_test.sv
